// ===== hdl/dmrt_pkg.sv =====
package dmrt_pkg;

   // Field widths fixed by the transaction format
   localparam int KEY_W  = 32;
   localparam int DATA_W = 64;
   localparam int SIZE_W = 11;

   // Serial modulo: one quotient bit per cycle over the sign-cleared key
   localparam int KEY_BITS   = 31;
   localparam int STEP_CNT_W = 5;
   localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(KEY_BITS - 1);

   localparam logic [KEY_W-1:0] SIGN_CLEAR_MASK = 32'h7FFF_FFFF;

   // Defaults for the top-level parameters
   localparam int DEF_TABLE_DEPTH  = 1024;
   localparam int DEF_RECORD_WIDTH = 64;

   localparam logic [SIZE_W-1:0] SLOT_LIMIT_RESET = 11'd1024;

   // Operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef struct packed {
      logic                     func;
      logic signed [KEY_W-1:0]  key;
      logic [DATA_W-1:0]        record_data;
   } req_item_type;

   typedef struct packed {
      logic                     success;
      logic [DATA_W-1:0]        found_data;
   } rsp_item_type;

   typedef struct packed {
      logic                     start;
      logic [KEY_BITS-1:0]      dividend;
      logic [SIZE_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic [SIZE_W-1:0]        remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                     en;
      logic                     write;
   } store_cmd_type;

endpackage

// ===== hdl/direct_mapped_record_table.sv =====
// Channel   Ports                        Direction  Moves
// request   req_valid/req_ready/req_item in         func, key, record_data
// response  rsp_valid/rsp_ready/rsp_item out        success, found_data
// csr       csr_we/csr_wdata             in         slot count, no wait
//
// One transaction at a time: the slot index comes from a bit-serial restoring
// modulo (one quotient bit per step), then one table access. After reset the
// valid map is swept one entry a cycle with req_ready low. A stalled response
// is held in the output register; the next request is still taken, and its
// result waits until that register frees.
module direct_mapped_record_table #(
   parameter int TABLE_DEPTH  = dmrt_pkg::DEF_TABLE_DEPTH,
   parameter int RECORD_WIDTH = dmrt_pkg::DEF_RECORD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  dmrt_pkg::req_item_type       req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dmrt_pkg::rsp_item_type       rsp_item,
   input  logic                         csr_we,
   input  logic [dmrt_pkg::SIZE_W-1:0]  csr_wdata
);
   import dmrt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_RESULT = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [SIZE_W-1:0]       tsize_ff;
   logic [SIZE_W-1:0]       eff_size;
   logic [SIZE_W-1:0]       size_ff;
   logic [SIZE_W-1:0]       count_ff, count_in;
   logic                    func_ff;
   logic [RECORD_WIDTH-1:0] rec_ff;
   logic                    ins_ok_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_item_ff, rsp_item_in;

   logic                    accept;
   logic                    ins_go;
   logic                    load;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   store_cmd_type           store_cmd;
   logic                    clear_busy;
   logic                    rd_valid;
   logic [RECORD_WIDTH-1:0] rd_data;

   // Table size register
   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= SLOT_LIMIT_RESET;
      end else if (csr_we) begin
         tsize_ff <= csr_wdata;
      end
   end

   // Clamp the programmed size to 1..TABLE_DEPTH
   always_comb begin
      eff_size = tsize_ff;
      if (tsize_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (32'(tsize_ff) > 32'(TABLE_DEPTH)) begin
         eff_size = SIZE_W'(TABLE_DEPTH);
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept    = req_valid && req_ready;

   // Slot index from the sign-cleared key
   assign div_req.start    = accept;
   assign div_req.dividend = KEY_BITS'(req_item.key & SIGN_CLEAR_MASK);
   assign div_req.divisor  = eff_size;

   dmrt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Table access issued as the remainder comes out
   assign ins_go          = div_rsp.done && (func_ff == FUNC_INSERT) && (count_ff < size_ff);
   assign store_cmd.en    = div_rsp.done;
   assign store_cmd.write = ins_go;

   dmrt_store #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .RECORD_WIDTH (RECORD_WIDTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .store_cmd  (store_cmd),
      .cmd_index  (IDX_W'(div_rsp.remainder)),
      .cmd_data   (rec_ff),
      .clear_busy (clear_busy),
      .rd_valid   (rd_valid),
      .rd_data    (rd_data)
   );

   // Captured transaction fields
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_item.func;
         rec_ff  <= req_item.record_data[RECORD_WIDTH-1:0];
         size_ff <= eff_size;
      end
      if (div_rsp.done) begin
         ins_ok_ff <= ins_go;
      end
   end

   assign count_in = ins_go ? (count_ff + 1'b1) : count_ff;

   // Sequencer
   assign load = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_rsp.done) state_in = ST_RESULT;
         ST_RESULT: if (load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_item_in.success    = (func_ff == FUNC_INSERT) ? ins_ok_ff : rd_valid;
      rsp_item_in.found_data = ((func_ff == FUNC_SEARCH) && rd_valid) ?
                               DATA_W'(rd_data) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("request taken during clearing sweep");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside divide state");

   a_count_on_insert: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(store_cmd.write))
      else $error("insert count moved without an insert");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result state");
`endif

endmodule

// ===== hdl/dmrt_divider.sv =====
module dmrt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  dmrt_pkg::div_req_type div_req,
   output dmrt_pkg::div_rsp_type div_rsp
);
   import dmrt_pkg::*;

   logic [KEY_BITS-1:0]   shift_ff;
   logic [SIZE_W-1:0]     div_ff;
   logic [SIZE_W-1:0]     rem_ff;
   logic [SIZE_W-1:0]     rem_in;
   logic [STEP_CNT_W-1:0] step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [SIZE_W:0]       trial;
   logic [SIZE_W:0]       diff;

   // Restoring step: bring in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, shift_ff[KEY_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign rem_in = (trial >= {1'b0, div_ff}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];

   // Step counter and handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend shift register and partial remainder
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         shift_ff <= div_req.dividend;
         div_ff   <= div_req.divisor;
         rem_ff   <= '0;
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[KEY_BITS-2:0], 1'b0};
         rem_ff   <= rem_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("done without a finished run");
`endif

endmodule

// ===== hdl/dmrt_store.sv =====
module dmrt_store #(
   parameter int TABLE_DEPTH  = dmrt_pkg::DEF_TABLE_DEPTH,
   parameter int RECORD_WIDTH = dmrt_pkg::DEF_RECORD_WIDTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dmrt_pkg::store_cmd_type store_cmd,
   input  logic [IDX_W-1:0]        cmd_index,
   input  logic [RECORD_WIDTH-1:0] cmd_data,
   output logic                    clear_busy,
   output logic                    rd_valid,
   output logic [RECORD_WIDTH-1:0] rd_data
);
   import dmrt_pkg::*;

   logic                    valid_mem [TABLE_DEPTH];
   logic [RECORD_WIDTH-1:0] rec_mem   [TABLE_DEPTH];

   logic             clear_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic             rd_valid_ff;
   logic [RECORD_WIDTH-1:0] rd_data_ff;

   // Post-reset sweep of the valid map
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         ptr_ff   <= '0;
      end else if (clear_ff) begin
         ptr_ff <= ptr_ff + 1'b1;
         if (ptr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // Valid map: one write port shared by the sweep and inserts
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         valid_mem[ptr_ff] <= 1'b0;
      end else if (store_cmd.en && store_cmd.write) begin
         valid_mem[cmd_index] <= 1'b1;
      end
      if (store_cmd.en) begin
         rd_valid_ff <= valid_mem[cmd_index];
      end
   end

   // Record memory
   always_ff @(posedge clock) begin
      if (store_cmd.en && store_cmd.write) begin
         rec_mem[cmd_index] <= cmd_data;
      end
      if (store_cmd.en) begin
         rd_data_ff <= rec_mem[cmd_index];
      end
   end

   assign clear_busy = clear_ff;
   assign rd_valid   = rd_valid_ff;
   assign rd_data    = rd_data_ff;

`ifndef SYNTHESIS
   a_no_access_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !store_cmd.en)
      else $error("table access during clearing sweep");
`endif

endmodule
